// ===== rtl/dqtk_pkg.sv =====
// ----------------------------------------------------------------------------
// dqtk_pkg: shared types and constants of the top-N dequantizing selector
// Field widths, configuration register indexes and default parameters.
// ----------------------------------------------------------------------------
package dqtk_pkg;

    localparam int SAMPLE_W    = 8;
    localparam int SCALE_W     = 24;
    localparam int TOPN_W      = 3;
    localparam int RANK_W      = 3;
    localparam int IDX_W       = 10;
    localparam int SCORE_W     = 33;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 48;
    localparam int M_PAD_W     = M_TDATA_W - RANK_W - IDX_W - SCORE_W;

    localparam int DEF_TOP_K     = 5;
    localparam int DEF_MAX_ITEMS = 1024;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ZERO_POINT = 2'd0,
        REG_SCALE      = 2'd1,
        REG_TOP_N      = 2'd2
    } cfg_reg_t;

endpackage

// ===== rtl/dequantize_top_n_classes.sv =====
// A tlast request loads the list into the snapshot registers; results then leave
// the output register one per cycle while m_tready is high (min(count, n_eff)).
// Throughput: one request per cycle; a tlast request waits in the input register
// until the previous vector's final result has moved into the output register.
// Reset: synchronous, active low; clears the list, counters, handshakes and sets
// zero_point 0, scale_q16 1.0, top_n 5.
// ----------------------------------------------------------------------------
// dequantize_top_n_classes: streaming top-N class selector with dequantization
// Input register, ranked list, and result sequencer with output register.
// ----------------------------------------------------------------------------
module dequantize_top_n_classes #(
    parameter int TOP_K     = dqtk_pkg::DEF_TOP_K,
    parameter int MAX_ITEMS = dqtk_pkg::DEF_MAX_ITEMS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [dqtk_pkg::CFG_ADDR_W-1:0]    cfg_index,
    input  logic [dqtk_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // sample [7:0]
    input  logic [dqtk_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // rank [2:0], class_index [12:3], score [45:13], zero [47:46]
    output logic [dqtk_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast
);
    import dqtk_pkg::*;

    localparam int CNT_W = $clog2(TOP_K + 1);

    logic [SAMPLE_W-1:0] zp_reg;
    logic [SCALE_W-1:0]  scale_reg;
    logic [TOPN_W-1:0]   topn_reg;

    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic                in_last_reg;

    logic                           in_advance;
    logic                           snap_load;
    logic                           snap_free;
    logic [TOP_K-1:0][SAMPLE_W-1:0] post_val;
    logic [TOP_K-1:0][IDX_W-1:0]    post_idx;
    logic [CNT_W-1:0]               post_filled;
    logic [CNT_W-1:0]               n_eff;
    logic [CNT_W-1:0]               snap_cnt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zp_reg    <= '0;
            scale_reg <= SCALE_W'(65536);
            topn_reg  <= TOPN_W'(5);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ZERO_POINT: zp_reg    <= cfg_data[SAMPLE_W-1:0];
                REG_SCALE:      scale_reg <= cfg_data[SCALE_W-1:0];
                REG_TOP_N:      topn_reg  <= cfg_data[TOPN_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_advance = in_valid_reg && (!in_last_reg || snap_free);
    assign s_tready   = !in_valid_reg || in_advance;
    assign snap_load  = in_advance && in_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (in_advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_sample_reg <= s_tdata[SAMPLE_W-1:0];
            in_last_reg   <= s_tlast;
        end
    end

    // zero reports one class, anything above the list depth reports all of it
    always_comb begin
        if (topn_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (32'(topn_reg) > TOP_K) begin
            n_eff = CNT_W'(TOP_K);
        end else begin
            n_eff = CNT_W'(topn_reg);
        end
    end

    assign snap_cnt = (post_filled < n_eff) ? post_filled : n_eff;

    dqtk_rank_list #(
        .TOP_K     (TOP_K),
        .MAX_ITEMS (MAX_ITEMS),
        .CNT_W     (CNT_W)
    ) u_list (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (in_advance),
        .sample      (in_sample_reg),
        .last        (in_last_reg),
        .post_val    (post_val),
        .post_idx    (post_idx),
        .post_filled (post_filled)
    );

    dqtk_emit #(
        .TOP_K (TOP_K),
        .CNT_W (CNT_W)
    ) u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .snap_load  (snap_load),
        .snap_cnt   (snap_cnt),
        .snap_val   (post_val),
        .snap_idx   (post_idx),
        .zero_point (zp_reg),
        .scale_q16  (scale_reg),
        .snap_free  (snap_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        snap_load |-> (snap_cnt != '0))
        else $error("vector ended with nothing to report");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_last_reg && !snap_free) |=> (in_valid_reg && in_last_reg))
        else $error("stalled end-of-vector request lost");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (n_eff != '0) && (n_eff <= CNT_W'(TOP_K)))
        else $error("report count out of range");
`endif

endmodule

// ===== rtl/dqtk_rank_list.sv =====
// ----------------------------------------------------------------------------
// dqtk_rank_list: ranked list of the best scores of the current vector
// Parallel compare-and-insert of one sample per advance cycle into a sorted
// register list; arrival counter saturates at MAX_ITEMS. Cleared at vector end.
// ----------------------------------------------------------------------------
module dqtk_rank_list #(
    parameter int TOP_K     = dqtk_pkg::DEF_TOP_K,
    parameter int MAX_ITEMS = dqtk_pkg::DEF_MAX_ITEMS,
    parameter int CNT_W     = $clog2(TOP_K + 1)
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         advance,
    input  logic [dqtk_pkg::SAMPLE_W-1:0]                sample,
    input  logic                                         last,
    output logic [TOP_K-1:0][dqtk_pkg::SAMPLE_W-1:0]     post_val,
    output logic [TOP_K-1:0][dqtk_pkg::IDX_W-1:0]        post_idx,
    output logic [CNT_W-1:0]                             post_filled
);
    import dqtk_pkg::*;

    localparam int ICNT_W = $clog2(MAX_ITEMS + 1);

    logic [TOP_K-1:0][SAMPLE_W-1:0] val_reg;
    logic [TOP_K-1:0][IDX_W-1:0]    idx_reg;
    logic [CNT_W-1:0]               filled_reg;
    logic [ICNT_W-1:0]              count_reg;

    logic             ins;
    logic [TOP_K-1:0] ge;
    logic [IDX_W-1:0] new_idx;

    assign ins     = advance && (count_reg < ICNT_W'(MAX_ITEMS));
    assign new_idx = IDX_W'(count_reg);

    // ge is a prefix of the valid entries: the new sample lands after all of them
    always_comb begin
        for (int i = 0; i < TOP_K; i++) begin
            ge[i] = (CNT_W'(i) < filled_reg) && ($signed(val_reg[i]) >= $signed(sample));
        end
    end

    always_comb begin
        post_val = val_reg;
        post_idx = idx_reg;
        if (ins) begin
            if (!ge[0]) begin
                post_val[0] = sample;
                post_idx[0] = new_idx;
            end
            for (int i = 1; i < TOP_K; i++) begin
                if (!ge[i]) begin
                    if (ge[i-1]) begin
                        post_val[i] = sample;
                        post_idx[i] = new_idx;
                    end else begin
                        post_val[i] = val_reg[i-1];
                        post_idx[i] = idx_reg[i-1];
                    end
                end
            end
        end
    end

    assign post_filled = (ins && (filled_reg < CNT_W'(TOP_K))) ? filled_reg + 1'b1 : filled_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filled_reg <= '0;
            count_reg  <= '0;
        end else if (advance) begin
            if (last) begin
                filled_reg <= '0;
                count_reg  <= '0;
            end else begin
                filled_reg <= post_filled;
                if (ins) begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && !last) begin
            val_reg <= post_val;
            idx_reg <= post_idx;
        end
    end

`ifndef SYNTHESIS
    // valid entries stay in non-increasing order
    for (genvar g = 0; g < TOP_K - 1; g++) begin : g_sorted
        assert property (@(posedge aclk) disable iff (!aresetn)
            (CNT_W'(g + 1) < filled_reg) |-> ($signed(val_reg[g]) >= $signed(val_reg[g+1])))
            else $error("rank list out of order");
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && last) |=> (filled_reg == '0) && (count_reg == '0))
        else $error("list not cleared at end of vector");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (ins && !last) |=> (filled_reg != '0) && (count_reg == $past(count_reg) + 1'b1))
        else $error("accepted sample not counted");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (filled_reg <= CNT_W'(TOP_K)) && (count_reg <= ICNT_W'(MAX_ITEMS)))
        else $error("list counters out of range");
`endif

endmodule

// ===== rtl/dqtk_emit.sv =====
// ----------------------------------------------------------------------------
// dqtk_emit: result sequencer and dequantizer
// Holds a snapshot of the ranked list, shifts it out one entry per result,
// scales (value - zero_point) by scale_q16 into the output register.
// ----------------------------------------------------------------------------
module dqtk_emit #(
    parameter int TOP_K = dqtk_pkg::DEF_TOP_K,
    parameter int CNT_W = $clog2(TOP_K + 1)
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         snap_load,
    input  logic [CNT_W-1:0]                             snap_cnt,
    input  logic [TOP_K-1:0][dqtk_pkg::SAMPLE_W-1:0]     snap_val,
    input  logic [TOP_K-1:0][dqtk_pkg::IDX_W-1:0]        snap_idx,
    input  logic [dqtk_pkg::SAMPLE_W-1:0]                zero_point,
    input  logic [dqtk_pkg::SCALE_W-1:0]                 scale_q16,
    output logic                                         snap_free,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // rank [2:0], class_index [12:3], score [45:13], zero [47:46]
    output logic [dqtk_pkg::M_TDATA_W-1:0]               m_tdata,
    output logic                                         m_tlast
);
    import dqtk_pkg::*;

    logic [TOP_K-1:0][SAMPLE_W-1:0] sval_reg;
    logic [TOP_K-1:0][IDX_W-1:0]    sidx_reg;
    logic [CNT_W-1:0]               left_reg;
    logic [CNT_W-1:0]               rank_reg;

    logic                       m_valid_reg;
    logic                       m_last_reg;
    logic [RANK_W-1:0]          m_rank_reg;
    logic [IDX_W-1:0]           m_idx_reg;
    logic signed [SCORE_W-1:0]  m_score_reg;

    logic                       busy;
    logic                       out_load;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [SCALE_W:0]    scale_s;
    logic signed [SCORE_W:0]    prod;

    assign busy      = (left_reg != '0);
    assign out_load  = busy && (!m_valid_reg || m_tready);
    assign snap_free = !busy || ((left_reg == CNT_W'(1)) && out_load);

    assign diff    = $signed({sval_reg[0][SAMPLE_W-1], sval_reg[0]})
                   - $signed({zero_point[SAMPLE_W-1], zero_point});
    assign scale_s = $signed({1'b0, scale_q16});
    assign prod    = diff * scale_s;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg    <= '0;
            rank_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (snap_load) begin
                left_reg <= snap_cnt;
                rank_reg <= '0;
            end else if (out_load) begin
                left_reg <= left_reg - 1'b1;
                rank_reg <= rank_reg + 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_load) begin
            sval_reg <= snap_val;
            sidx_reg <= snap_idx;
        end else if (out_load) begin
            for (int i = 0; i < TOP_K - 1; i++) begin
                sval_reg[i] <= sval_reg[i+1];
                sidx_reg[i] <= sidx_reg[i+1];
            end
        end
        if (out_load) begin
            m_rank_reg  <= RANK_W'(rank_reg);
            m_idx_reg   <= sidx_reg[0];
            m_score_reg <= prod[SCORE_W-1:0];
            m_last_reg  <= (left_reg == CNT_W'(1));
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_score_reg, m_idx_reg, m_rank_reg};

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        snap_load |-> snap_free)
        else $error("snapshot overwritten while results pending");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (left_reg == CNT_W'(1))) |=> (m_tvalid && m_tlast))
        else $error("final result not marked");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (left_reg != CNT_W'(1))) |=> (m_tvalid && !m_tlast))
        else $error("early final mark");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (left_reg <= CNT_W'(TOP_K)) && (rank_reg <= CNT_W'(TOP_K)))
        else $error("result counters out of range");
`endif

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: regression bench for the dequantize_top_n_classes selector
// Streams class-score vectors with random bursts and back-pressure, keeps its
// own ranked top-N list and checks every result with its dequantized score.
// ----------------------------------------------------------------------------
module tb;
    import dqtk_pkg::*;

    localparam int LIST_DEPTH   = DEF_TOP_K;
    localparam int ITEM_LIMIT   = DEF_MAX_ITEMS;
    localparam int IDX_LSB      = RANK_W;
    localparam int SCORE_LSB    = RANK_W + IDX_W;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [CFG_ADDR_W-1:0] REG_NONE = 2'd3;  // unmapped register index

    typedef struct {
        logic [RANK_W-1:0]  rank;
        logic [IDX_W-1:0]   class_index;
        logic [SCORE_W-1:0] score;
        logic               final_res;
    } ranked_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_HOLD, RX_SPARSE} rx_mode_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;   // sample [7:0]
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;          // rank [2:0], class_index [12:3], score [45:13]
    logic                   m_tlast;

    // predicted block state
    logic signed [SAMPLE_W-1:0] zp_reg    = '0;
    logic [SCALE_W-1:0]         scale_reg = 24'd65536;
    logic [TOPN_W-1:0]          topn_reg  = 3'd5;
    logic signed [SAMPLE_W-1:0] kept_val [LIST_DEPTH];
    logic [IDX_W-1:0]           kept_idx [LIST_DEPTH];
    int                         kept_cnt  = 0;
    int                         arrivals  = 0;
    ranked_t                    ranked_q[$];

    int       errors     = 0;
    int       burst_left = 0;
    rx_mode_t rx_mode    = RX_OPEN;
    int       rx_left    = 0;

    dequantize_top_n_classes uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("dequantize_top_n_classes regression: fail");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
    endtask

    // exact (sample - zero_point) * scale, 16 fraction bits
    function automatic logic [SCORE_W-1:0] dequant(input logic signed [SAMPLE_W-1:0] v);
        longint d;
        longint prod;
        d = longint'(v) - longint'(zp_reg);
        prod = d * longint'(scale_reg);
        return prod[SCORE_W-1:0];
    endfunction

    function automatic void rank_score(input logic signed [SAMPLE_W-1:0] v, input logic last);
        int pos;
        int i;
        int n;
        int cnt;
        ranked_t r;
        if (arrivals < ITEM_LIMIT) begin
            pos = 0;
            // equal scores stay ahead: ties go to the earlier index
            while (pos < kept_cnt && kept_val[pos] >= v) pos++;
            if (pos < LIST_DEPTH) begin
                i = (kept_cnt < LIST_DEPTH) ? kept_cnt : LIST_DEPTH - 1;
                while (i > pos) begin
                    kept_val[i] = kept_val[i-1];
                    kept_idx[i] = kept_idx[i-1];
                    i--;
                end
                kept_val[pos] = v;
                kept_idx[pos] = arrivals[IDX_W-1:0];
                if (kept_cnt < LIST_DEPTH) kept_cnt++;
            end
            arrivals++;
        end
        if (last) begin
            n = int'(topn_reg);
            if (n == 0) n = 1;
            if (n > LIST_DEPTH) n = LIST_DEPTH;
            cnt = (kept_cnt < n) ? kept_cnt : n;
            for (int k = 0; k < cnt; k++) begin
                r.rank        = k[RANK_W-1:0];
                r.class_index = kept_idx[k];
                r.score       = dequant(kept_val[k]);
                r.final_res   = (k + 1 == cnt);
                ranked_q.push_back(r);
            end
            kept_cnt = 0;
            arrivals = 0;
        end
    endfunction

    // one request; valid stays up across a burst, drops for the gap after it
    task automatic push_score(input logic [SAMPLE_W-1:0] v, input logic last);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        rank_score(v, last);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 15);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (ranked_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_ZERO_POINT: zp_reg    = data[SAMPLE_W-1:0];
            REG_SCALE:      scale_reg = data[SCALE_W-1:0];
            REG_TOP_N:      topn_reg  = data[TOPN_W-1:0];
            default: ;
        endcase
    endtask

    // unused upper bits carry noise; the block must ignore them
    function automatic logic [CFG_DATA_W-1:0] noisy(input logic [7:0] low);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom);
        d[7:0] = low;
        return d;
    endfunction

    task automatic set_regs(input logic [7:0] zp, input logic [SCALE_W-1:0] sc,
                            input logic [TOPN_W-1:0] tn);
        wait_drained();
        write_reg(REG_ZERO_POINT, noisy(zp));
        write_reg(REG_SCALE, sc);
        write_reg(REG_TOP_N, {noisy(8'h00)} & ~24'h7 | 24'(tn));
    endtask

    // receiver ready follows segments of random kind and length
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(1, 40);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_HOLD:   m_tready <= 1'b0;
            default:   m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        ranked_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (ranked_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result tdata=%h tlast=%b",
                                          m_tdata, m_tlast));
            end else begin
                want = ranked_q.pop_front();
                if (m_tdata[RANK_W-1:0] !== want.rank)
                    report_mismatch($sformatf("rank %0d, want %0d",
                                              m_tdata[RANK_W-1:0], want.rank));
                if (m_tdata[IDX_LSB +: IDX_W] !== want.class_index)
                    report_mismatch($sformatf("rank %0d class_index %0d, want %0d", want.rank,
                                              m_tdata[IDX_LSB +: IDX_W], want.class_index));
                if (m_tdata[SCORE_LSB +: SCORE_W] !== want.score)
                    report_mismatch($sformatf("rank %0d score %h, want %h", want.rank,
                                              m_tdata[SCORE_LSB +: SCORE_W], want.score));
                if (m_tlast !== want.final_res)
                    report_mismatch($sformatf("rank %0d final %b, want %b", want.rank,
                                              m_tlast, want.final_res));
            end
        end
    end

    // reset register values, extremes, ties, short vector
    task automatic test_reset_defaults();
        push_score(8'h7F, 1'b0);
        push_score(8'h80, 1'b0);
        push_score(8'h00, 1'b0);
        push_score(8'h7F, 1'b0);
        push_score(8'hFF, 1'b0);
        push_score(8'h01, 1'b0);
        push_score(8'h7F, 1'b1);
        push_score(8'h42, 1'b1);    // one-item vector, fewer results than top_n
    endtask

    task automatic test_ties();
        repeat (4) push_score(8'h80, 1'b0);
        push_score(8'h80, 1'b1);
    endtask

    task automatic test_register_extremes();
        set_regs(8'h80, 24'hFFFFFF, 3'd5);
        push_score(8'h7F, 1'b0);
        push_score(8'h80, 1'b1);
        // top_n zero acts as one
        set_regs(8'h7F, 24'hFFFFFF, 3'd0);
        push_score(8'h80, 1'b0);
        push_score(8'h80, 1'b1);
        // zero scale, top_n above the list depth
        set_regs(8'h00, 24'h000000, 3'd7);
        write_reg(REG_NONE, 24'hFFFFFF);
        push_score(8'h05, 1'b0);
        push_score(8'hF9, 1'b0);
        push_score(8'h09, 1'b0);
        push_score(8'h10, 1'b0);
        push_score(8'h80, 1'b0);
        push_score(8'h7F, 1'b1);
    endtask

    // past the item limit scores are not ranked but last still ends the run
    task automatic test_index_limit();
        logic [SAMPLE_W-1:0] v;
        set_regs(8'h00, 24'd65536, 3'd5);
        for (int i = 0; i < ITEM_LIMIT + 6; i++) begin
            if (i >= ITEM_LIMIT)  v = 8'h7F;
            else if (i == 300)    v = 8'd126;
            else if (i == 517)    v = 8'd125;
            else if (i == ITEM_LIMIT - 1) v = 8'd126;
            else v = SAMPLE_W'($urandom_range(0, 228)) - 8'd128;
            push_score(v, i == ITEM_LIMIT + 5);
        end
    endtask

    task automatic test_random_vectors();
        int sent;
        int len;
        int base;
        for (int phase = 0; phase < 12; phase++) begin
            case ($urandom_range(0, 3))
                0: set_regs(($urandom_range(0, 1) != 0) ? 8'h80 : 8'h7F,
                            ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000001,
                            TOPN_W'($urandom_range(0, 7)));
                1: set_regs(8'h00, 24'd65536, TOPN_W'($urandom_range(1, 5)));
                default: set_regs(8'($urandom), 24'($urandom_range(0, 24'hFFFFFF)),
                                  TOPN_W'($urandom_range(0, 7)));
            endcase
            sent = 0;
            while (sent < 30) begin
                len  = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 12);
                base = $urandom_range(0, 255);
                for (int j = 0; j < len; j++) begin
                    // narrow windows give plenty of ties
                    if (base[0])
                        push_score(8'(base + $urandom_range(0, 2)), j == len - 1);
                    else
                        push_score(8'($urandom), j == len - 1);
                end
                sent += len;
                if (phase == 5 && sent == len) wait_drained();
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_ties();
        test_register_extremes();
        test_index_limit();
        test_random_vectors();
        wait_drained();
        repeat (20) @(posedge aclk);
        if (ranked_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", ranked_q.size()));
        if (errors == 0) begin
            $display("dequantize_top_n_classes regression: pass");
        end else begin
            $display("dequantize_top_n_classes regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dqtk_pkg.sv
rtl/dqtk_rank_list.sv
rtl/dqtk_emit.sv
rtl/dequantize_top_n_classes.sv
verif/tb.sv
